### rtl/core/bisp_pkg.sv
// Shared constants for the page-format image scaler.
`default_nettype none
package bisp_pkg;

    localparam int STORE_DEPTH_DEF = 16384;
    localparam int SCREEN_COLUMNS  = 128;
    localparam int SCREEN_ROWS     = 64;
    localparam int PAGE_ROWS       = 8;

    localparam int COL_SHIFT = $clog2(SCREEN_COLUMNS);
    localparam int ROW_SHIFT = $clog2(SCREEN_ROWS);

    localparam int DIM_W     = 8;
    localparam int IDX_W     = 14;
    localparam int PAGE_W    = 3;
    localparam int COLUMN_W  = 7;
    localparam int MAC_W     = 17;
    localparam int ACC_W     = 14;
    localparam int CFG_IDX_W = 2;

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [DIM_W-1:0] SRC_WIDTH_RST  = 8'd128;
    localparam logic [DIM_W-1:0] SRC_HEIGHT_RST = 8'd64;

endpackage
`default_nettype wire

### rtl/core/bisp_mac.sv
// Shared multiply-accumulate unit for column, row and address arithmetic.
`default_nettype none
module bisp_mac
    import bisp_pkg::*;
(
    input  wire logic [DIM_W-1:0] a,
    input  wire logic [DIM_W-1:0] b,
    input  wire logic [DIM_W-1:0] c,
    output logic      [MAC_W-1:0] p
);

    assign p = MAC_W'(a) * MAC_W'(b) + MAC_W'(c);

endmodule
`default_nettype wire

### rtl/core/bisp_store.sv
// One-bit pixel store with a single port and a clearing pass after reset.
`default_nettype none
module bisp_store
    import bisp_pkg::*;
#(
    parameter int DEPTH = STORE_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic          wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] addr,
    output logic               rd_data,
    output logic               clr_busy
);

    logic          mem [DEPTH];
    logic [AW-1:0] clr_cnt_reg;
    logic [AW-1:0] clr_cnt_next;
    logic          clr_busy_reg;
    logic          clr_busy_next;
    logic          rd_data_reg;

    always_comb
    begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
            if (clr_cnt_reg == AW'(DEPTH - 1))
            begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else
        begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_cnt_reg] <= 1'b0;
        end
        else if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule
`default_nettype wire

### rtl/core/binary_image_scale_to_pages.sv
// Top level: nearest-neighbour scaler from a one-bit image store to display page bytes.
//
// Input stream: s_tuser is the command (0 load a pixel, 1 read a page byte).
// A load writes one pixel, if its index lies inside the store, at the edge it
// is taken and is ready again at once. A read runs a sequencer round one
// shared 8x8 multiply-add unit: ST_COL forms the source column, ST_BASE the
// first row product, then ST_ADDR forms the eight pixel addresses in turn,
// while the single-port store returns one bit per cycle through the address
// register and its read register. ST_DRAIN waits for the store reads to
// drain, ST_DONE hands the byte to the output register once that register
// is free or being taken, and the sequencer then returns to idle.
// Output stream: one byte per read, held in an output register; the block
// takes new requests while it waits, and a second finished byte waits in the
// sequencer until the receiver takes the first.
// Configuration: cfg_index 0 is the source width, 1 the source height;
// writes are always taken and other indexes are dropped.
// Reset: the store is cleared one entry a cycle, all STORE_DEPTH entries,
// with s_tready low meanwhile; width returns to 128 and height to 64.
`default_nettype none
module binary_image_scale_to_pages
    import bisp_pkg::*;
#(
    parameter int STORE_DEPTH = STORE_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // pixel_index[13:0], pixel_value[14], page[17:15], column[24:18], zero pad
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // cmd
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // page_byte[7:0], out_page[10:8], out_column[17:11], zero pad
    output logic      [OUT_DATA_W-1:0] m_tdata,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [DIM_W-1:0]      cfg_data
);

    localparam int AW = $clog2(STORE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL,
        ST_BASE,
        ST_ADDR,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [DIM_W-1:0]        width_reg;
    logic [DIM_W-1:0]        height_reg;
    logic [PAGE_W-1:0]       page_reg;
    logic [COLUMN_W-1:0]     column_reg;
    logic [DIM_W-1:0]        col_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic [2:0]              bit_reg;
    logic [AW-1:0]           addr_reg;
    logic                    ok1_reg;
    logic [2:0]              b1_reg;
    logic                    s1_valid_reg;
    logic                    ok2_reg;
    logic [2:0]              b2_reg;
    logic                    s2_valid_reg;
    logic [7:0]              byte_reg;
    logic                    m_tvalid_reg;
    logic [OUT_DATA_W-1:0]   m_data_reg;

    logic [DIM_W-1:0]        mac_a;
    logic [DIM_W-1:0]        mac_b;
    logic [DIM_W-1:0]        mac_c;
    logic [MAC_W-1:0]        mac_p;

    logic                    clr_busy;
    logic                    rd_bit;
    logic                    in_fire;
    logic                    load_fire;
    logic                    in_range;
    logic                    out_load;
    logic [AW-1:0]           st_addr;

    logic [IDX_W-1:0]        in_pixel_index;
    logic                    in_pixel_value;
    logic [PAGE_W-1:0]       in_page;
    logic [COLUMN_W-1:0]     in_column;

    assign in_pixel_index = s_tdata[IDX_W-1:0];
    assign in_pixel_value = s_tdata[IDX_W];
    assign in_page        = s_tdata[IDX_W+PAGE_W:IDX_W+1];
    assign in_column      = s_tdata[IDX_W+PAGE_W+COLUMN_W:IDX_W+PAGE_W+1];

    assign s_tready  = (state_reg == ST_IDLE) && !clr_busy;
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (s_tuser == CMD_LOAD);
    assign in_range  = MAC_W'(in_pixel_index) < MAC_W'(STORE_DEPTH);
    assign st_addr   = load_fire ? AW'(in_pixel_index) : addr_reg;
    assign out_load  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        mac_a = '0;
        mac_b = width_reg;
        mac_c = '0;
        unique case (state_reg)
            ST_COL:
            begin
                mac_a = DIM_W'(column_reg);
            end
            ST_BASE:
            begin
                mac_a = DIM_W'({page_reg, 3'b000});
                mac_b = height_reg;
            end
            ST_ADDR:
            begin
                mac_a = DIM_W'(acc_reg >> ROW_SHIFT);
                mac_c = col_reg;
            end
            default:
            begin
                mac_a = '0;
            end
        endcase
    end

    bisp_mac u_mac (
        .a (mac_a),
        .b (mac_b),
        .c (mac_c),
        .p (mac_p)
    );

    bisp_store #(
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (load_fire && in_range),
        .wr_data  (in_pixel_value),
        .rd_en    (s1_valid_reg),
        .addr     (st_addr),
        .rd_data  (rd_bit),
        .clr_busy (clr_busy)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (s_tuser == CMD_READ))
                begin
                    state_next = ST_COL;
                end
            end
            ST_COL:   state_next = ST_BASE;
            ST_BASE:  state_next = ST_ADDR;
            ST_ADDR:
            begin
                if (bit_reg == 3'(PAGE_ROWS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (s2_valid_reg && !s1_valid_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            width_reg    <= SRC_WIDTH_RST;
            height_reg   <= SRC_HEIGHT_RST;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= (state_reg == ST_ADDR);
            s2_valid_reg <= s1_valid_reg;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_SRC_WIDTH:  width_reg  <= cfg_data;
                    REG_SRC_HEIGHT: height_reg <= cfg_data;
                    default:        width_reg  <= width_reg;
                endcase
            end
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            page_reg   <= in_page;
            column_reg <= in_column;
        end
        if (state_reg == ST_COL)
        begin
            col_reg <= DIM_W'(mac_p >> COL_SHIFT);
        end
        if (state_reg == ST_BASE)
        begin
            acc_reg <= ACC_W'(mac_p);
            bit_reg <= '0;
        end
        if (state_reg == ST_ADDR)
        begin
            addr_reg <= AW'(mac_p);
            ok1_reg  <= MAC_W'(mac_p) < MAC_W'(STORE_DEPTH);
            b1_reg   <= bit_reg;
            acc_reg  <= acc_reg + ACC_W'(height_reg);
            bit_reg  <= bit_reg + 3'd1;
        end
        if (s1_valid_reg)
        begin
            ok2_reg <= ok1_reg;
            b2_reg  <= b1_reg;
        end
        if (s2_valid_reg)
        begin
            byte_reg[b2_reg] <= rd_bit && ok2_reg;
        end
        if (out_load)
        begin
            m_data_reg <= OUT_DATA_W'({column_reg, page_reg, byte_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

    a_no_request_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n)
        clr_busy |-> !s_tready
    ) else $error("request taken during store clearing pass");

    a_read_starts_sequence: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_fire && (s_tuser == CMD_READ)) |=> (state_reg == ST_COL)
    ) else $error("read request did not start the sequencer");

    a_store_read_in_sequence: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> ((state_reg == ST_ADDR) || (state_reg == ST_DRAIN))
    ) else $error("store read outside address sequence");

    a_done_pipeline_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> (!s1_valid_reg && !s2_valid_reg)
    ) else $error("byte finished with reads still in flight");

endmodule
`default_nettype wire
